[sv/lcdst_pkg.sv]
`default_nettype none

package lcdst_pkg;

  // Field widths
  localparam int unsigned ElapsedW = 8;
  localparam int unsigned LineW    = 8;
  localparam int unsigned BudgetW  = 11;

  typedef logic [ElapsedW-1:0]       elapsed_t;
  typedef logic [LineW-1:0]          line_t;
  typedef logic signed [BudgetW-1:0] budget_t;

  // Line timing
  localparam int unsigned VisibleCycles   = 960;
  localparam int unsigned HblankCycles    = 272;
  localparam int unsigned VblankFirstLnN  = 160;
  localparam int unsigned VblankLinesN    = 68;

  localparam budget_t VisibleLen      = budget_t'(VisibleCycles);
  localparam budget_t HblankLen       = budget_t'(HblankCycles);
  localparam line_t   VblankFirstLine = line_t'(VblankFirstLnN);
  localparam line_t   LastLine        = line_t'(VblankFirstLnN + VblankLinesN - 1);

  // APB register map: register i at byte address 4*i
  localparam int unsigned AddrW   = 4;
  localparam int unsigned RegIdxW = 2;
  typedef logic [RegIdxW-1:0] reg_idx_t;

  localparam reg_idx_t RegLineCompare  = 2'd0;
  localparam reg_idx_t RegMatchIrqEn   = 2'd1;
  localparam reg_idx_t RegHblankIrqEn  = 2'd2;
  localparam reg_idx_t RegVblankIrqEn  = 2'd3;

  typedef struct packed {
    line_t line_compare;
    logic  match_irq_en;
    logic  hblank_irq_en;
    logic  vblank_irq_en;
  } cfg_t;

  typedef struct packed {
    line_t line_count;
    logic  in_hblank;
    logic  in_vblank;
    logic  line_matches;
    logic  irq_hblank;
    logic  irq_vblank;
    logic  irq_match;
  } result_t;

endpackage

`default_nettype wire

[sv/lcdst_if.sv]
`default_nettype none

// Input channel: elapsed cycle reports
interface lcdst_in_if;
  import lcdst_pkg::*;

  logic     valid;
  logic     ready;
  elapsed_t elapsed_cycles;

  modport source (output valid, output elapsed_cycles, input ready);
  modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

// Output channel: timing status per item
interface lcdst_out_if;
  import lcdst_pkg::*;

  logic  valid;
  logic  ready;
  line_t line_count;
  logic  in_hblank;
  logic  in_vblank;
  logic  line_matches;
  logic  irq_hblank;
  logic  irq_vblank;
  logic  irq_match;

  modport source (output valid, output line_count, output in_hblank, output in_vblank,
                  output line_matches, output irq_hblank, output irq_vblank,
                  output irq_match, input ready);
  modport sink   (input valid, input line_count, input in_hblank, input in_vblank,
                  input line_matches, input irq_hblank, input irq_vblank,
                  input irq_match, output ready);
endinterface

`default_nettype wire

[sv/lcdst_line_engine.sv]
`default_nettype none

module lcdst_line_engine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire lcdst_pkg::elapsed_t elapsed_i,
  input  wire lcdst_pkg::cfg_t    cfg_i,
  output lcdst_pkg::result_t      result_o
);
  import lcdst_pkg::*;

  budget_t budget_q, budget_d;
  logic    hblank_q, hblank_d;
  line_t   line_q, line_d;
  logic    vblank_q, vblank_d;
  logic    match_q, match_d;

  budget_t budget_left;
  logic    phase_done;
  line_t   line_next;
  logic    irq_h, irq_v, irq_m;

  // Charge the elapsed cycles against the budget
  assign budget_left = budget_q - budget_t'({{(BudgetW-ElapsedW){1'b0}}, elapsed_i});
  assign phase_done  = budget_left[BudgetW-1] || (budget_left == '0);
  assign line_next   = (line_q >= LastLine) ? '0 : line_q + line_t'(1);

  // One phase change at most, deficit carries into the next phase
  always_comb begin
    budget_d = budget_left;
    hblank_d = hblank_q;
    line_d   = line_q;
    vblank_d = vblank_q;
    match_d  = match_q;
    irq_h    = 1'b0;
    irq_v    = 1'b0;
    irq_m    = 1'b0;
    if (phase_done) begin
      if (!hblank_q) begin
        hblank_d = 1'b1;
        irq_h    = cfg_i.hblank_irq_en;
        budget_d = budget_left + HblankLen;
      end else begin
        hblank_d = 1'b0;
        line_d   = line_next;
        match_d  = (line_next == cfg_i.line_compare);
        irq_m    = match_d && cfg_i.match_irq_en;
        if (line_next == VblankFirstLine) begin
          vblank_d = 1'b1;
          irq_v    = cfg_i.vblank_irq_en;
        end else if (line_next == '0) begin
          vblank_d = 1'b0;
        end
        budget_d = budget_left + VisibleLen;
      end
    end
  end

  // Advance the line state once per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= VisibleLen;
      hblank_q <= 1'b0;
      line_q   <= '0;
      vblank_q <= 1'b0;
      match_q  <= 1'b0;
    end else if (step_i) begin
      budget_q <= budget_d;
      hblank_q <= hblank_d;
      line_q   <= line_d;
      vblank_q <= vblank_d;
      match_q  <= match_d;
    end
  end

  always_comb begin
    result_o.line_count   = line_d;
    result_o.in_hblank    = hblank_d;
    result_o.in_vblank    = vblank_d;
    result_o.line_matches = match_d;
    result_o.irq_hblank   = irq_h;
    result_o.irq_vblank   = irq_v;
    result_o.irq_match    = irq_m;
  end

endmodule

`default_nettype wire

[sv/lcd_scanline_timing_generator_core.sv]
`default_nettype none

// The result passes through the input register and the result register; a stall
// on the output side can hold it in either.
// Throughput: one item per cycle while the output does not stall; the line state
// updates in a single pass of subtract, compare and increment between the two registers.
// Reset (rst_ni low, asynchronous): budget 960, visible phase, line 0, all flags
// and configuration registers 0, both pipeline stages empty.
module lcd_scanline_timing_generator_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  lcdst_in_if.sink                   in_i,
  lcdst_out_if.source                out_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [lcdst_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import lcdst_pkg::*;

  cfg_t     cfg_q;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  logic     s1_valid_q;
  elapsed_t s1_elapsed_q;
  logic     out_valid_q;
  result_t  out_q;
  result_t  step_result;
  logic     s1_advance;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:AddrW-RegIdxW];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegLineCompare: cfg_q.line_compare  <= pwdata[LineW-1:0];
        RegMatchIrqEn:  cfg_q.match_irq_en  <= pwdata[0];
        RegHblankIrqEn: cfg_q.hblank_irq_en <= pwdata[0];
        RegVblankIrqEn: cfg_q.vblank_irq_en <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegLineCompare: prdata[LineW-1:0] = cfg_q.line_compare;
      RegMatchIrqEn:  prdata[0]         = cfg_q.match_irq_en;
      RegHblankIrqEn: prdata[0]         = cfg_q.hblank_irq_en;
      RegVblankIrqEn: prdata[0]         = cfg_q.vblank_irq_en;
    endcase
  end

  // Pipeline flow: the input stage moves on whenever the result slot frees up
  assign s1_advance = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_elapsed_q <= in_i.elapsed_cycles;
    end
  end

  lcdst_line_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_advance),
    .elapsed_i (s1_elapsed_q),
    .cfg_i     (cfg_q),
    .result_o  (step_result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_q <= step_result;
    end
  end

  // Drive the output channel
  assign out_o.valid        = out_valid_q;
  assign out_o.line_count   = out_q.line_count;
  assign out_o.in_hblank    = out_q.in_hblank;
  assign out_o.in_vblank    = out_q.in_vblank;
  assign out_o.line_matches = out_q.line_matches;
  assign out_o.irq_hblank   = out_q.irq_hblank;
  assign out_o.irq_vblank   = out_q.irq_vblank;
  assign out_o.irq_match    = out_q.irq_match;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`default_nettype none

module tb;
  import lcdst_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 4;
  localparam int unsigned LinesPerFrame = VblankFirstLnN + VblankLinesN;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lcdst_in_if  elapsed_if ();
  lcdst_out_if status_if ();

  lcd_scanline_timing_generator_core uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (elapsed_if),
    .out_o   (status_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the timing state and registers
  cfg_t    shadow_cfg;
  budget_t budget;
  logic    in_hb;
  line_t   cur_line;
  logic    vb_flag;
  logic    match_flag;

  result_t status_q[$];
  int unsigned errors;
  int unsigned cycle_cnt;
  bit          idle_on;
  int unsigned sink_hold;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Advance the line timing by one elapsed-cycle report
  function automatic result_t advance_timing(elapsed_t cyc);
    result_t r;
    r = '0;
    budget = budget - budget_t'(cyc);
    if (budget <= 0) begin
      if (!in_hb) begin
        in_hb = 1'b1;
        r.irq_hblank = shadow_cfg.hblank_irq_en;
        budget = budget + HblankLen;
      end else begin
        in_hb = 1'b0;
        cur_line = (cur_line >= LastLine) ? line_t'(0) : cur_line + line_t'(1);
        match_flag = (cur_line == shadow_cfg.line_compare);
        if (match_flag) r.irq_match = shadow_cfg.match_irq_en;
        if (cur_line == VblankFirstLine) begin
          vb_flag = 1'b1;
          r.irq_vblank = shadow_cfg.vblank_irq_en;
        end else if (cur_line == line_t'(0)) begin
          vb_flag = 1'b0;
        end
        budget = budget + VisibleLen;
      end
    end
    r.line_count   = cur_line;
    r.in_hblank    = in_hb;
    r.in_vblank    = vb_flag;
    r.line_matches = match_flag;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Bias toward large reports so the run moves through many lines and vblank
  function automatic elapsed_t pick_elapsed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 93) return elapsed_t'($urandom_range(232, 255));
    if (r < 97) return elapsed_t'($urandom_range(0, 255));
    if (r < 99) return elapsed_t'(0);
    return elapsed_t'(255);
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got)
      note_error($sformatf("mismatch %s: expected %0d, got %0d", name, want, got));
  endtask

  // Send one report and record the status it should produce
  task automatic send_report(elapsed_t cyc);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      elapsed_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    elapsed_if.valid          <= 1'b1;
    elapsed_if.elapsed_cycles <= cyc;
    @(posedge clk);
    while (!elapsed_if.ready) @(posedge clk);
    status_q.push_back(advance_timing(cyc));
    @(negedge clk);
  endtask

  // Hold the input and wait until every status has come back
  task automatic drain();
    elapsed_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic read_reg(reg_idx_t idx, logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrW'(idx) << 2;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want)
      note_error($sformatf("register %0d readback: expected %0h, got %0h", idx, want, prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write one register, mirror it in the shadow copy, then read it back
  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    logic [31:0] kept;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx) << 2;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegLineCompare: begin
        shadow_cfg.line_compare = data[LineW-1:0];
        kept = 32'(data[LineW-1:0]);
      end
      RegMatchIrqEn: begin
        shadow_cfg.match_irq_en = data[0];
        kept = 32'(data[0]);
      end
      RegHblankIrqEn: begin
        shadow_cfg.hblank_irq_en = data[0];
        kept = 32'(data[0]);
      end
      default: begin
        shadow_cfg.vblank_irq_en = data[0];
        kept = 32'(data[0]);
      end
    endcase
    @(negedge clk);
    read_reg(idx, kept);
  endtask

  task automatic set_config(line_t cmp, logic m_en, logic h_en, logic v_en);
    drain();
    write_reg(RegLineCompare, 32'(cmp));
    write_reg(RegMatchIrqEn, 32'(m_en));
    write_reg(RegHblankIrqEn, 32'(h_en));
    write_reg(RegVblankIrqEn, 32'(v_en));
  endtask

  // Registers come out of reset cleared
  task automatic test_reset_readback();
    read_reg(RegLineCompare, 32'h0);
    read_reg(RegMatchIrqEn, 32'h0);
    read_reg(RegHblankIrqEn, 32'h0);
    read_reg(RegVblankIrqEn, 32'h0);
  endtask

  // Zero reports change nothing and raise no pulse
  task automatic test_zero_elapsed();
    send_report(elapsed_t'(0));
    send_report(elapsed_t'(0));
  endtask

  // Upper bits of wide writes are dropped; land exactly on zero, then just below
  task automatic test_phase_boundaries();
    drain();
    write_reg(RegLineCompare, 32'hFFFF_FF01);
    write_reg(RegMatchIrqEn, 32'hFFFF_FFFF);
    write_reg(RegHblankIrqEn, 32'hFFFF_FFFF);
    write_reg(RegVblankIrqEn, 32'hFFFF_FFFF);
    repeat (3) send_report(elapsed_t'(255));
    send_report(elapsed_t'(195));
    send_report(elapsed_t'(1));
    send_report(elapsed_t'(255));
    send_report(elapsed_t'(17));
  endtask

  // Overshoot both phases and carry the deficit; walk each input bit
  task automatic test_deficit_carry();
    idle_on = 1'b1;
    repeat (4) send_report(elapsed_t'(255));
    send_report(elapsed_t'(255));
    for (int b = 0; b < ElapsedW; b++) send_report(elapsed_t'(1) << b);
  endtask

  // Random reports across most of a frame, under several register settings
  task automatic test_random_frame();
    line_t cmp;
    for (int ph = 0; ph < 5; ph++) begin
      cmp = line_t'((int'(cur_line) + $urandom_range(5, 40)) % LinesPerFrame);
      case (ph)
        0: set_config(cmp, 1'b1, 1'b1, 1'b0);
        1: set_config(line_t'(255), 1'b1, 1'b0, 1'b1);
        2: set_config(cmp, 1'b0, 1'b1, 1'b1);
        3: set_config(VblankFirstLine, 1'b1, 1'b1, 1'b1);
        default: set_config(line_t'(0), 1'b1, 1'($urandom_range(0, 1)), 1'b1);
      endcase
      idle_on = (ph != 1);
      repeat (185) send_report(pick_elapsed());
    end
  endtask

  // Ready side: stall at random unless idling is off
  always @(negedge clk) begin
    if (rst_n) begin
      if (sink_hold > 0) begin
        sink_hold--;
        status_if.ready <= 1'b0;
      end else begin
        status_if.ready <= 1'b1;
        sink_hold = pick_gap();
      end
    end
  end

  // Compare each status transfer with the oldest prediction
  always @(posedge clk) begin : check_status
    result_t want;
    if (rst_n && status_if.valid && status_if.ready) begin
      if (status_q.size() == 0) begin
        note_error($sformatf("status with no prediction: line %0d", status_if.line_count));
      end else begin
        want = status_q.pop_front();
        check_field("line_count", want.line_count, status_if.line_count);
        check_field("in_hblank", want.in_hblank, status_if.in_hblank);
        check_field("in_vblank", want.in_vblank, status_if.in_vblank);
        check_field("line_matches", want.line_matches, status_if.line_matches);
        check_field("irq_hblank", want.irq_hblank, status_if.irq_hblank);
        check_field("irq_vblank", want.irq_vblank, status_if.irq_vblank);
        check_field("irq_match", want.irq_match, status_if.irq_match);
      end
    end
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    elapsed_if.valid          = 1'b0;
    elapsed_if.elapsed_cycles = '0;
    status_if.ready           = 1'b0;
    errors    = 0;
    cycle_cnt = 0;
    sink_hold = 0;
    idle_on   = 1'b0;
    shadow_cfg = '0;
    budget     = VisibleLen;
    in_hb      = 1'b0;
    cur_line   = '0;
    vb_flag    = 1'b0;
    match_flag = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_readback();
    test_zero_elapsed();
    test_phase_boundaries();
    test_deficit_carry();
    test_random_frame();

    drain();
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/lcdst_pkg.sv
sv/lcdst_if.sv
sv/lcdst_line_engine.sv
sv/lcd_scanline_timing_generator_core.sv
tb/sv/tb.sv
